// ===== sv/vbc_pkg.sv =====
// Shared constants, entry layout and control structs for the vertical box clusterer.
package vbc_pkg;

  localparam int MaxClusters = 32;
  localparam int CoordBits   = 12;
  localparam int FracBits    = 4;

  localparam int IdxW     = $clog2(MaxClusters);
  localparam int UseW     = $clog2(MaxClusters + 1);
  localparam int AvgW     = CoordBits + FracBits;
  localparam int MidW     = CoordBits + 2;
  localparam int BotW     = CoordBits + 1;
  localparam int MemCntW  = 16;
  localparam int DvdW     = AvgW + MemCntW + 1;
  localparam int DvsW     = MemCntW + 1;
  localparam int StepW    = $clog2(DvdW + 1);
  localparam int AreaW    = 2 * CoordBits;
  localparam int OvW      = 2 * BotW;

  localparam int InDataW  = 4 * CoordBits;
  localparam int OutDataW = 8;
  localparam int OutUserW = 2;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = CoordBits;

  localparam logic [CfgIdxW-1:0]   RegHeightLimit   = 2'd0;
  localparam logic [CfgIdxW-1:0]   RegBorderLimit   = 2'd1;
  localparam logic [CfgDataW-1:0]  HeightLimitReset = 12'd10;
  localparam logic [CfgDataW-1:0]  BorderLimitReset = 12'd80;
  localparam logic [MemCntW-1:0]   CountMax         = 16'hFFFF;

  typedef struct packed {
    logic [MidW-1:0]      mid;
    logic [AvgW-1:0]      avg_w;
    logic [AvgW-1:0]      avg_h;
    logic [BotW-1:0]      bottom;
    logic [CoordBits-1:0] left;
    logic [CoordBits-1:0] top;
    logic [CoordBits-1:0] width;
    logic [CoordBits-1:0] height;
    logic [MemCntW-1:0]   count;
  } entry_t;

  typedef struct packed {
    logic load_box;
    logic rd_entry;
    logic calc;
    logic inc_idx;
    logic mul;
    logic div_start;
    logic div_step;
    logic wr_join;
    logic wr_new;
  } cmd_t;

  typedef struct packed {
    logic at_end;
    logic hit;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

// ===== sv/vbc_ctrl.sv =====
// Sequencer for scan, join arithmetic and result hand-off.
module vbc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vbc_pkg::stat_t stat_i,
  output vbc_pkg::cmd_t  cmd_o
);
  import vbc_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StScan, StCalc, StChk, StMul, StDivStart, StDiv, StJoin, StNew
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_box = 1'b1;
          state_d        = StScan;
        end
      end
      StScan: begin
        if (stat_i.at_end) begin
          state_d = StNew;
        end else begin
          cmd_o.rd_entry = 1'b1;
          state_d        = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = StChk;
      end
      StChk: begin
        if (stat_i.hit) begin
          state_d = StMul;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d       = StScan;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StDivStart;
      end
      StDivStart: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        if (stat_i.div_done) begin
          state_d = StJoin;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StJoin: begin
        if (!stat_i.out_busy) begin
          cmd_o.wr_join = 1'b1;
          state_d       = StIdle;
        end
      end
      StNew: begin
        if (!stat_i.out_busy) begin
          cmd_o.wr_new = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/vbc_dp.sv =====
// Cluster table, match tests, running-average divider and result register.
module vbc_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vbc_pkg::cmd_t                  cmd_i,
  output vbc_pkg::stat_t                 stat_o,
  input  logic [vbc_pkg::CoordBits-1:0]  box_left_i,
  input  logic [vbc_pkg::CoordBits-1:0]  box_top_i,
  input  logic [vbc_pkg::CoordBits-1:0]  box_width_i,
  input  logic [vbc_pkg::CoordBits-1:0]  box_height_i,
  input  logic                           frame_start_i,
  input  logic                           cfg_we_i,
  input  logic [vbc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [vbc_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [vbc_pkg::IdxW-1:0]       cluster_index_o,
  output logic                           opened_new_o,
  output logic                           table_full_o,
  output logic [vbc_pkg::UseW-1:0]       in_use_o
);
  import vbc_pkg::*;

  // config
  logic [CfgDataW-1:0] height_limit_q, border_limit_q;

  // box and scan control
  logic [CoordBits-1:0] bl_q, bt_q, bw_q, bh_q;
  logic [AreaW-1:0]     area_q;
  logic [UseW-1:0]      idx_q, in_use_q;

  // table
  entry_t mem_q [MaxClusters];
  entry_t rd_q;
  entry_t wr_data;
  logic   wr_en;
  logic [IdxW-1:0] wr_addr;

  // test pipeline
  logic [OvW-1:0]   ov_q;
  logic [AreaW-1:0] area2_q;
  logic             ovp_q, tests_q;

  // divider
  logic [2*AvgW-1:0] pw_q, ph_q;
  logic [DvdW-1:0]   dvd_w_q, dvd_h_q;
  logic [DvsW-1:0]   rem_w_q, rem_h_q, dvs_q;
  logic [StepW-1:0]  step_q;

  // result
  logic            out_valid_q, out_new_q, out_full_q;
  logic [IdxW-1:0] out_idx_q;

  logic full;
  assign full = (in_use_q == UseW'(MaxClusters));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_limit_q <= HeightLimitReset;
      border_limit_q <= BorderLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegHeightLimit: height_limit_q <= cfg_data_i;
        RegBorderLimit: border_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // combinational tests on the entry just read
  logic [MidW-1:0]      mid2, dm;
  logic [BotW-1:0]      bx1, ex1, by1, ey1, x1, y1, x0e, y0e, dx, dy, db;
  logic [CoordBits-1:0] x0, y0;
  logic [AvgW-1:0]      bh_fx, dh, hlim_fx;
  logic [MidW+7:0]      mid_lhs, mid_rhs;
  logic                 ovp_c, tests_c;

  always_comb begin
    mid2    = (MidW'(bl_q) << 1) + MidW'(bw_q);
    bx1     = BotW'(bl_q) + BotW'(bw_q);
    ex1     = BotW'(rd_q.left) + BotW'(rd_q.width);
    by1     = BotW'(bt_q) + BotW'(bh_q);
    ey1     = BotW'(rd_q.top) + BotW'(rd_q.height);
    x0      = (bl_q > rd_q.left) ? bl_q : rd_q.left;
    y0      = (bt_q > rd_q.top) ? bt_q : rd_q.top;
    x1      = (bx1 < ex1) ? bx1 : ex1;
    y1      = (by1 < ey1) ? by1 : ey1;
    x0e     = BotW'(x0);
    y0e     = BotW'(y0);
    ovp_c   = (x1 > x0e) && (y1 > y0e);
    dx      = x1 - x0e;
    dy      = y1 - y0e;
    dm      = (mid2 >= rd_q.mid) ? (mid2 - rd_q.mid) : (rd_q.mid - mid2);
    // |dmid| < 0.7 * avg_width, in half pixels with FracBits fraction
    mid_lhs = (MidW+8)'(dm) * (MidW+8)'(10 << FracBits);
    mid_rhs = (MidW+8)'(rd_q.avg_w) * (MidW+8)'(14);
    bh_fx   = AvgW'(bh_q) << FracBits;
    dh      = (bh_fx >= rd_q.avg_h) ? (bh_fx - rd_q.avg_h) : (rd_q.avg_h - bh_fx);
    hlim_fx = AvgW'(height_limit_q) << FracBits;
    db      = (BotW'(bt_q) >= rd_q.bottom) ? (BotW'(bt_q) - rd_q.bottom)
                                           : (rd_q.bottom - BotW'(bt_q));
    tests_c = (mid_lhs < mid_rhs) && (dh < hlim_fx) && (db < BotW'(border_limit_q));
  end

  // partial-overlap decision on registered products
  logic [OvW+3:0] ov10, a1, a1x9, a2, a2x9;
  logic           partial;
  always_comb begin
    ov10    = (OvW+4)'(ov_q) * (OvW+4)'(10);
    a1      = (OvW+4)'(area_q);
    a1x9    = (OvW+4)'(area_q) * (OvW+4)'(9);
    a2      = (OvW+4)'(area2_q);
    a2x9    = (OvW+4)'(area2_q) * (OvW+4)'(9);
    partial = ovp_q && (ov10 > a1) && (ov10 < a1x9) && (ov10 > a2) && (ov10 < a2x9);
  end

  // divider step, two lanes sharing divisor
  logic [DvsW:0] trial_w, trial_h;
  logic          qb_w, qb_h;
  always_comb begin
    trial_w = {rem_w_q, dvd_w_q[DvdW-1]};
    trial_h = {rem_h_q, dvd_h_q[DvdW-1]};
    qb_w    = (trial_w >= {1'b0, dvs_q});
    qb_h    = (trial_h >= {1'b0, dvs_q});
  end

  // write-back
  logic [BotW-1:0] bot_new;
  always_comb begin
    bot_new = (rd_q.bottom > by1) ? rd_q.bottom : by1;
    wr_data.mid    = mid2;
    wr_data.left   = bl_q;
    wr_data.top    = bt_q;
    wr_data.width  = bw_q;
    wr_data.height = bh_q;
    if (cmd_i.wr_join) begin
      wr_data.avg_w  = dvd_w_q[AvgW-1:0];
      wr_data.avg_h  = dvd_h_q[AvgW-1:0];
      wr_data.bottom = bot_new;
      wr_data.count  = (rd_q.count < CountMax) ? rd_q.count + 1'b1 : rd_q.count;
      wr_addr        = idx_q[IdxW-1:0];
    end else begin
      wr_data.avg_w  = AvgW'(bw_q) << FracBits;
      wr_data.avg_h  = AvgW'(bh_q) << FracBits;
      wr_data.bottom = by1;
      wr_data.count  = MemCntW'(1);
      wr_addr        = in_use_q[IdxW-1:0];
    end
    wr_en = cmd_i.wr_join || (cmd_i.wr_new && !full);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_entry) begin
      rd_q <= mem_q[idx_q[IdxW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_box) begin
      bl_q   <= box_left_i;
      bt_q   <= box_top_i;
      bw_q   <= box_width_i;
      bh_q   <= box_height_i;
      area_q <= AreaW'(box_width_i) * AreaW'(box_height_i);
    end
    if (cmd_i.calc) begin
      ov_q    <= OvW'(dx) * OvW'(dy);
      area2_q <= AreaW'(rd_q.width) * AreaW'(rd_q.height);
      ovp_q   <= ovp_c;
      tests_q <= tests_c;
    end
    if (cmd_i.mul) begin
      pw_q <= (2*AvgW)'(rd_q.avg_w) * (2*AvgW)'(rd_q.count);
      ph_q <= (2*AvgW)'(rd_q.avg_h) * (2*AvgW)'(rd_q.count);
    end
    if (cmd_i.div_start) begin
      dvd_w_q <= DvdW'(pw_q) + (DvdW'(bw_q) << FracBits);
      dvd_h_q <= DvdW'(ph_q) + (DvdW'(bh_q) << FracBits);
      rem_w_q <= '0;
      rem_h_q <= '0;
      dvs_q   <= DvsW'(rd_q.count) + 1'b1;
    end else if (cmd_i.div_step) begin
      dvd_w_q <= {dvd_w_q[DvdW-2:0], qb_w};
      dvd_h_q <= {dvd_h_q[DvdW-2:0], qb_h};
      rem_w_q <= qb_w ? DvsW'(trial_w - {1'b0, dvs_q}) : trial_w[DvsW-1:0];
      rem_h_q <= qb_h ? DvsW'(trial_h - {1'b0, dvs_q}) : trial_h[DvsW-1:0];
    end
    if (cmd_i.wr_join) begin
      out_idx_q  <= idx_q[IdxW-1:0];
      out_new_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else if (cmd_i.wr_new) begin
      out_idx_q  <= full ? '0 : in_use_q[IdxW-1:0];
      out_new_q  <= !full;
      out_full_q <= full;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      in_use_q    <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_box) begin
        idx_q <= '0;
        if (frame_start_i) begin
          in_use_q <= '0;
        end
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.wr_new && !full) begin
        in_use_q <= in_use_q + 1'b1;
      end
      if (cmd_i.div_start) begin
        step_q <= StepW'(DvdW);
      end else if (cmd_i.div_step) begin
        step_q <= step_q - 1'b1;
      end
      if (cmd_i.wr_join || cmd_i.wr_new) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.at_end   = (idx_q == in_use_q);
  assign stat_o.hit      = tests_q && !partial;
  assign stat_o.div_done = (step_q == '0);
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign cluster_index_o = out_idx_q;
  assign opened_new_o    = out_new_q;
  assign table_full_o    = out_full_q;
  assign in_use_o        = in_use_q;

endmodule

// ===== sv/vertical_box_clusterer.sv =====
// Top level of the vertical box clusterer: ports, controller and datapath.
//
// Boxes enter on the s_axis channel, sorted by top edge, one request each;
// every box yields exactly one result request on m_axis. frame_start in
// s_axis_tuser empties the cluster table before that box is handled.
// Each box is scanned against the open clusters one entry at a time through
// a single-port table with a registered read. A box that joins a cluster
// also runs a 33-step restoring divider for both running averages; the
// table holds up to 32 open clusters.
// The result sits in an output register; the next box is accepted while it
// waits, and the block holds before write-back until the receiver takes it.
// Reset empties the table (count of open clusters to zero) and loads the
// limits with height 10 and border 80. The config channel is always ready
// and must only be written while the block is idle.
module vertical_box_clusterer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // box_left[11:0], box_top[23:12], box_width[35:24], box_height[47:36]
  input  logic [vbc_pkg::InDataW-1:0]    s_axis_tdata,
  // frame_start[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // cluster_index[4:0], zero pad [7:5]
  output logic [vbc_pkg::OutDataW-1:0]   m_axis_tdata,
  // opened_new[0], table_full[1]
  output logic [vbc_pkg::OutUserW-1:0]   m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vbc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [vbc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import vbc_pkg::*;

  cmd_t            cmd;
  stat_t           stat;
  logic [IdxW-1:0] cluster_index;
  logic            opened_new, table_full;
  logic [UseW-1:0] in_use;

  assign cfg_ready_o = 1'b1;

  vbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vbc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .box_left_i      (s_axis_tdata[CoordBits-1:0]),
    .box_top_i       (s_axis_tdata[2*CoordBits-1:CoordBits]),
    .box_width_i     (s_axis_tdata[3*CoordBits-1:2*CoordBits]),
    .box_height_i    (s_axis_tdata[4*CoordBits-1:3*CoordBits]),
    .frame_start_i   (s_axis_tuser),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .cluster_index_o (cluster_index),
    .opened_new_o    (opened_new),
    .table_full_o    (table_full),
    .in_use_o        (in_use)
  );

  assign m_axis_tdata = OutDataW'(cluster_index);
  assign m_axis_tuser = {table_full, opened_new};

`ifndef ASSERT_OFF
  a_in_use_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_use <= UseW'(MaxClusters))
    else $error("open cluster count past table size");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(opened_new && table_full))
    else $error("result both opened and dropped");

  a_one_box_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new box taken while one is in flight");

  // flag reflects the count as it stood when the new-cluster write was tried
  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_new |=> (table_full == $past(in_use == UseW'(MaxClusters))))
    else $error("table_full flag disagrees with cluster count");
`endif

endmodule

// ===== verif/vertical_box_clusterer_test.sv =====
// Self-checking testbench for the vertical box clusterer: directed and random box streams.
module vertical_box_clusterer_test;
  import vbc_pkg::*;

  typedef struct packed {
    logic [4:0] idx;
    logic       opened;
    logic       full;
  } verdict_t;

  typedef struct {
    logic [11:0] left, top, width, height;
  } rect_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  vertical_box_clusterer dut (.*);

  initial forever #4 clk_i = ~clk_i;

  // Shadow copy of the cluster table
  longint unsigned tbl_mid[MaxClusters], tbl_aw[MaxClusters], tbl_ah[MaxClusters];
  longint unsigned tbl_bot[MaxClusters], tbl_cnt[MaxClusters];
  rect_t tbl_last[MaxClusters];
  int unsigned in_use = 0;
  longint unsigned hgt_lim = 10, brd_lim = 80;

  verdict_t verdicts_due[$];
  int errors = 0;
  int unsigned cur_top = 0;

  function automatic longint unsigned adiff(longint unsigned a, longint unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic bit partly_covered(rect_t a, rect_t b);
    longint unsigned x0, x1, y0, y1, ov, a1, a2, ax1, bx1, ay1, by1;
    ax1 = longint'(a.left) + a.width;
    bx1 = longint'(b.left) + b.width;
    ay1 = longint'(a.top) + a.height;
    by1 = longint'(b.top) + b.height;
    x0 = a.left > b.left ? a.left : b.left;
    x1 = ax1 < bx1 ? ax1 : bx1;
    y0 = a.top > b.top ? a.top : b.top;
    y1 = ay1 < by1 ? ay1 : by1;
    if (x1 <= x0 || y1 <= y0) return 0;
    ov = 10 * (x1 - x0) * (y1 - y0);
    a1 = longint'(a.width) * a.height;
    a2 = longint'(b.width) * b.height;
    return ov > a1 && ov < 9 * a1 && ov > a2 && ov < 9 * a2;
  endfunction

  function automatic longint unsigned next_avg(longint unsigned avg, longint unsigned n,
                                               longint unsigned v);
    return (avg * n + (v << FracBits)) / (n + 1);
  endfunction

  // Assign one box to a cluster and update the shadow table
  function automatic verdict_t place_box(rect_t b, bit fresh);
    verdict_t r;
    longint unsigned mid2, dm, dh, db;
    int found;
    found = -1;
    if (fresh) in_use = 0;
    mid2 = 2 * longint'(b.left) + b.width;
    for (int i = 0; i < in_use; i++) begin
      if (partly_covered(b, tbl_last[i])) continue;
      dm = adiff(mid2, tbl_mid[i]);
      dh = adiff(longint'(b.height) << FracBits, tbl_ah[i]);
      db = adiff(b.top, tbl_bot[i]);
      if (((dm * 10) << FracBits) < 14 * tbl_aw[i] && dh < (hgt_lim << FracBits) &&
          db < brd_lim) begin
        found = i;
        break;
      end
    end
    r = '0;
    if (found >= 0) begin
      tbl_aw[found] = next_avg(tbl_aw[found], tbl_cnt[found], b.width);
      tbl_ah[found] = next_avg(tbl_ah[found], tbl_cnt[found], b.height);
      tbl_mid[found] = mid2;
      if (b.top + longint'(b.height) > tbl_bot[found]) tbl_bot[found] = b.top + longint'(b.height);
      tbl_last[found] = b;
      if (tbl_cnt[found] < 65535) tbl_cnt[found]++;
      r.idx = found[4:0];
    end else if (in_use < MaxClusters) begin
      tbl_mid[in_use] = mid2;
      tbl_aw[in_use] = longint'(b.width) << FracBits;
      tbl_ah[in_use] = longint'(b.height) << FracBits;
      tbl_bot[in_use] = b.top + longint'(b.height);
      tbl_last[in_use] = b;
      tbl_cnt[in_use] = 1;
      r.idx = in_use[4:0];
      r.opened = 1'b1;
      in_use++;
    end else r.full = 1'b1;
    return r;
  endfunction

  task automatic send_box(logic [11:0] l, t, w, h, bit fresh);
    rect_t b;
    repeat ($urandom_range(0, 19)) @(posedge clk_i);
    b.left = l; b.top = t; b.width = w; b.height = h;
    s_axis_tdata <= {h, w, t, l};
    s_axis_tuser <= fresh;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    verdicts_due = {verdicts_due, place_box(b, fresh)};
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CfgIdxW-1:0] idx, logic [11:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == RegHeightLimit) hgt_lim = val;
    else if (idx == RegBorderLimit) brd_lim = val;
    @(posedge clk_i);
  endtask

  // Result receiver with random stalls
  initial begin
    verdict_t e;
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(0, 19);
      if (n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      if (verdicts_due.size() == 0) begin
        $error("result with no box pending");
        errors++;
      end else begin
        e = verdicts_due.pop_front();
        if (m_axis_tdata[4:0] !== e.idx) begin
          $error("cluster_index exp %0d got %0d", e.idx, m_axis_tdata[4:0]); errors++;
        end
        if (m_axis_tuser[0] !== e.opened) begin
          $error("opened_new exp %0d got %0d", e.opened, m_axis_tuser[0]); errors++;
        end
        if (m_axis_tuser[1] !== e.full) begin
          $error("table_full exp %0d got %0d", e.full, m_axis_tuser[1]); errors++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_box(12'd0, 12'd0, 12'd1, 12'd1, 1);
    send_box(12'd0, 12'd0, 12'd4095, 12'd4095, 0);
    send_box(12'd4095, 12'd4095, 12'd4095, 12'd4095, 0);
    send_box(12'd4095, 12'd4095, 12'd0, 12'd0, 0);   // degenerate box
    send_box(12'd100, 12'd10, 12'd20, 12'd30, 1);
    send_box(12'd102, 12'd45, 12'd20, 12'd30, 0);    // joins column
    send_box(12'd105, 12'd50, 12'd20, 12'd30, 0);    // partial overlap, skips
    send_box(12'd100, 12'd80, 12'd20, 12'd30, 0);
    send_box(12'd100, 12'd80, 12'd20, 12'd30, 0);    // full overlap is fine
    send_box(12'd2000, 12'd90, 12'd15, 12'd25, 0);
    send_box(12'd101, 12'd300, 12'd20, 12'd30, 0);   // beyond border
  endtask

  // Fill the table: spread columns far apart
  task automatic test_table_full();
    for (int i = 0; i < 36; i++)
      send_box(12'(i * 120), 12'd0, 12'd10, 12'd10, i == 0);
    send_box(12'd4000, 12'd5, 12'd3, 12'd3, 0);
  endtask

  task automatic test_count_saturation();
    // border limit is zero, so no box joins and every count stays at one; saturation is out of reach
    for (int i = 0; i < 40; i++)
      send_box(12'd500, 12'd0, 12'd8, 12'd8, i == 0);
  endtask

  task automatic random_boxes(int n);
    logic [11:0] l, w, h;
    for (int i = 0; i < n; i++) begin
      bit fresh;
      fresh = ($urandom_range(0, 39) == 0);
      if (fresh) cur_top = 0;
      if ($urandom_range(0, 9) == 0) begin
        send_box(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), fresh);
      end else begin
        // columns on a coarse grid so many boxes join
        l = 12'($urandom_range(0, 7) * 400 + $urandom_range(0, 12));
        w = 12'($urandom_range(8, 24));
        h = 12'($urandom_range(10, 30));
        cur_top += $urandom_range(0, 40);
        if (cur_top > 4000) cur_top = $urandom_range(0, 50);
        send_box(l, 12'(cur_top), w, h, fresh);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    drain();
    write_limit(RegHeightLimit, 12'd0);
    write_limit(RegBorderLimit, 12'd4095);
    test_table_full();
    drain();
    write_limit(RegHeightLimit, 12'd4095);
    write_limit(RegBorderLimit, 12'd0);
    test_count_saturation();
    drain();
    write_limit(RegHeightLimit, 12'd6);
    write_limit(RegBorderLimit, 12'd60);
    random_boxes(800);
    drain();
    write_limit(RegHeightLimit, 12'd15);
    write_limit(RegBorderLimit, 12'd120);
    random_boxes(750);
    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
